### design/rdld_pkg.sv
// Shared constants, register indexes and types for the refresh divisor lock detector.
package rdld_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int WEIGHT_BITS    = 16;
	localparam int IN_BITS        = 28;
	localparam int NATIVE_BITS    = 28;
	localparam int OBS_BITS       = 4;
	localparam int TICK_BITS      = 3;
	localparam int FRAME_BITS     = 30;
	localparam int CFG_DATA_BITS  = 28;
	localparam int CFG_INDEX_BITS = 3;

	localparam int MAX_DIVISOR_DEF = 4;
	localparam int PERIOD_BITS_DEF = 28;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_NATIVE_PERIOD     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_TOLERANCE   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LONGEST_PERIOD    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AVERAGE_WEIGHT    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCK_OBSERVATIONS = 3'd4;

	localparam logic [NATIVE_BITS-1:0] NATIVE_PERIOD_RST     = 28'd1666667;
	localparam logic [WEIGHT_BITS-1:0] MATCH_TOLERANCE_RST   = 16'd1311;
	localparam logic [IN_BITS-1:0]     LONGEST_PERIOD_RST    = 28'd10000000;
	localparam logic [WEIGHT_BITS-1:0] AVERAGE_WEIGHT_RST    = 16'd6554;
	localparam logic [OBS_BITS-1:0]    LOCK_OBSERVATIONS_RST = 4'd8;

	// Request to the serial multiplier: start pulse and half-LSB rounding addend.
	typedef struct packed {
		logic start;
		logic round;
	} mul_req_t;

endpackage

### design/rdld_sermul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, optional rounding addend.
module rdld_sermul #(
	parameter int A_BITS = rdld_pkg::PERIOD_BITS_DEF + rdld_pkg::FRAC_BITS,
	parameter int B_BITS = rdld_pkg::WEIGHT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rdld_pkg::mul_req_t       req,
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic [A_BITS+B_BITS-1:0] product,
	output logic                     done
);

	localparam int P_BITS = A_BITS + B_BITS;
	localparam int C_BITS = $clog2(B_BITS + 1);
	localparam logic [P_BITS-1:0] ROUND = P_BITS'(64'd1 << (rdld_pkg::FRAC_BITS - 1));

	logic [P_BITS-1:0] a_q;
	logic [P_BITS-1:0] acc_q;
	logic [B_BITS-1:0] b_q;
	logic [C_BITS-1:0] cnt_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			acc_q  <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q   <= P_BITS'(a);
				b_q   <= b;
				acc_q <= req.round ? ROUND : '0;
				cnt_q <= C_BITS'(B_BITS);
			end else if (cnt_q != '0) begin
				// add the shifted multiplicand where the current bit is set
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q - C_BITS'(1);
				if (cnt_q == C_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

### design/refresh_divisor_lock_detector.sv
// Top level of the refresh divisor lock detector: averager, divisor search and handshakes.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------------
//  input    | in        | in_valid / in_stall   | period[27:0]
//  result   | out       | out_valid / out_stall | locked, frame_ticks[2:0],
//           |           |                       | frame_period[29:0]
//  config   | in        | cfg_we                | cfg_index[2:0], cfg_data[27:0]
//
// One item is worked on at a time: in_stall stays high from the input transfer until the
// result moves into the output register. A rejected interval or a first sample that does
// not search goes straight to the result; a later sample runs the average step multiply,
// and a sample that searches then runs the tolerance multiply and tries the divisors in
// turn (a first sample that searches skips the step). Reset clears the average, the count
// and both handshakes; a result held under out_stall does not block the next input transfer.
module refresh_divisor_lock_detector #(
	parameter int MAX_DIVISOR = rdld_pkg::MAX_DIVISOR_DEF,
	parameter int PERIOD_BITS = rdld_pkg::PERIOD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rdld_pkg::IN_BITS-1:0]         period,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 locked,
	output logic [rdld_pkg::TICK_BITS-1:0]       frame_ticks,
	output logic [rdld_pkg::FRAME_BITS-1:0]      frame_period,
	input  logic                                 cfg_we,
	input  logic [rdld_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [rdld_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int FRAC = rdld_pkg::FRAC_BITS;
	localparam int WB   = rdld_pkg::WEIGHT_BITS;
	// average width, Q.16
	localparam int AW   = PERIOD_BITS + FRAC;
	// divisor counter width
	localparam int DW   = $clog2(MAX_DIVISOR + 1);
	// target width, native period in Q.16
	localparam int TW   = rdld_pkg::NATIVE_BITS + FRAC;
	// search width: wide enough for n*avg and for the target
	localparam int SW   = ((AW > TW) ? AW : TW) + DW;
	// width for rounding the frame period
	localparam int FW   = ((SW + 1) > (FRAC + rdld_pkg::FRAME_BITS)) ?
		(SW + 1) : (FRAC + rdld_pkg::FRAME_BITS);
	// width for clamping the period
	localparam int PW   = (PERIOD_BITS > rdld_pkg::IN_BITS) ? PERIOD_BITS : rdld_pkg::IN_BITS;
	localparam logic [PW-1:0] PCLAMP = PW'((64'd1 << PERIOD_BITS) - 64'd1);
	localparam logic [FW-1:0] HALF   = FW'(64'd1 << (FRAC - 1));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_TOL,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// configuration registers
	logic [rdld_pkg::NATIVE_BITS-1:0] native_q;
	logic [WB-1:0]                    tol_q;
	logic [rdld_pkg::IN_BITS-1:0]     longest_q;
	logic [WB-1:0]                    weight_q;
	logic [rdld_pkg::OBS_BITS-1:0]    obs_q;

	state_t                           state_q;
	logic [AW-1:0]                    avg_q;
	logic [rdld_pkg::OBS_BITS-1:0]    count_q;
	logic                             search_q;
	logic                             dir_q;
	logic [AW-1:0]                    mul_a_q;
	logic [WB-1:0]                    mul_b_q;
	rdld_pkg::mul_req_t               mul_req_q;
	logic [AW+WB-1:0]                 t_q;
	logic [SW-1:0]                    scaled_q;
	logic [SW+FRAC-1:0]               tscaled_q;
	logic [DW-1:0]                    n_q;
	logic                             res_locked_q;
	logic [rdld_pkg::TICK_BITS-1:0]   res_ticks_q;
	logic [rdld_pkg::FRAME_BITS-1:0]  res_frame_q;
	logic                             out_valid_q;
	logic                             locked_q;
	logic [rdld_pkg::TICK_BITS-1:0]   ticks_q;
	logic [rdld_pkg::FRAME_BITS-1:0]  frame_q;

	logic [AW+WB-1:0]                 mul_prod;
	logic                             mul_done;

	rdld_pkg::mul_req_t               mul_req;
	logic                             bad;
	logic [PW-1:0]                    period_w;
	logic [PERIOD_BITS-1:0]           period_c;
	logic [AW-1:0]                    sample;
	logic [AW-1:0]                    mag;
	logic [AW-1:0]                    step;
	logic [AW-1:0]                    avg_n;
	logic [rdld_pkg::OBS_BITS-1:0]    need;
	logic [rdld_pkg::OBS_BITS-1:0]    count_inc;
	logic                             search_now;
	logic [SW-1:0]                    target;
	logic [SW-1:0]                    diff;
	logic                             match;
	logic [FW-1:0]                    frame_sum;

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_q  <= rdld_pkg::NATIVE_PERIOD_RST;
			tol_q     <= rdld_pkg::MATCH_TOLERANCE_RST;
			longest_q <= rdld_pkg::LONGEST_PERIOD_RST;
			weight_q  <= rdld_pkg::AVERAGE_WEIGHT_RST;
			obs_q     <= rdld_pkg::LOCK_OBSERVATIONS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rdld_pkg::CFG_NATIVE_PERIOD:     native_q  <= cfg_data;
				rdld_pkg::CFG_MATCH_TOLERANCE:   tol_q     <= cfg_data[WB-1:0];
				rdld_pkg::CFG_LONGEST_PERIOD:    longest_q <= cfg_data;
				rdld_pkg::CFG_AVERAGE_WEIGHT:    weight_q  <= cfg_data[WB-1:0];
				rdld_pkg::CFG_LOCK_OBSERVATIONS: obs_q     <= cfg_data[rdld_pkg::OBS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// one shared multiplier: first the average step, then avg * tolerance
	rdld_sermul #(
		.A_BITS (AW),
		.B_BITS (WB)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req_q),
		.a       (mul_a_q),
		.b       (mul_b_q),
		.product (mul_prod),
		.done    (mul_done)
	);

	always_comb begin
		// a zero interval or one longer than the longest period clears the average and the count
		bad      = (period == '0) || (period > longest_q);
		period_w = PW'(period);
		period_c = (period_w > PCLAMP) ? PCLAMP[PERIOD_BITS-1:0] : period_w[PERIOD_BITS-1:0];
		sample   = {period_c, {FRAC{1'b0}}};
		mag      = (sample >= avg_q) ? (sample - avg_q) : (avg_q - sample);

		// the product already carries the half-LSB addend, so the step is a plain shift
		step  = mul_prod[AW+FRAC-1:FRAC];
		avg_n = dir_q ? (avg_q + step) : (avg_q - step);

		// a zero observation limit counts as one
		need       = (obs_q == '0) ? rdld_pkg::OBS_BITS'(1) : obs_q;
		count_inc  = count_q + rdld_pkg::OBS_BITS'(1);
		search_now = (count_q < need) ? !(count_inc < need) : 1'b1;

		// |target - n*avg| * 2^16 <= n * (avg * tol)
		target = SW'({native_q, {FRAC{1'b0}}});
		diff   = (target >= scaled_q) ? (target - scaled_q) : (scaled_q - target);
		match  = {diff, {FRAC{1'b0}}} <= tscaled_q;

		frame_sum = FW'(scaled_q) + HALF;

		// start the step multiply on a later sample, the tolerance multiply once searching
		mul_req = '0;
		if (state_q == ST_IDLE && in_valid && !bad && (count_q != '0 || search_now)) begin
			mul_req.start = 1'b1;
			mul_req.round = (count_q != '0);
		end else if (state_q == ST_STEP && mul_done && search_q) begin
			mul_req.start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			avg_q        <= '0;
			count_q      <= '0;
			search_q     <= 1'b0;
			dir_q        <= 1'b0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			mul_req_q    <= '0;
			t_q          <= '0;
			scaled_q     <= '0;
			tscaled_q    <= '0;
			n_q          <= '0;
			res_locked_q <= 1'b0;
			res_ticks_q  <= '0;
			res_frame_q  <= '0;
			out_valid_q  <= 1'b0;
			locked_q     <= 1'b0;
			ticks_q      <= '0;
			frame_q      <= '0;
		end else begin
			mul_req_q <= mul_req;
			// raise valid as a result enters the output register, drop it once taken
			if (state_q == ST_FINISH && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (bad) begin
							avg_q        <= '0;
							count_q      <= '0;
							res_locked_q <= 1'b0;
							res_ticks_q  <= '0;
							res_frame_q  <= '0;
							state_q      <= ST_FINISH;
						end else begin
							if (count_q < need) begin
								count_q <= count_inc;
							end
							search_q <= search_now;
							if (count_q == '0) begin
								// first sample loads the average
								avg_q <= sample;
								if (search_now) begin
									mul_a_q <= sample;
									mul_b_q <= tol_q;
									state_q <= ST_TOL;
								end else begin
									res_locked_q <= 1'b0;
									res_ticks_q  <= '0;
									res_frame_q  <= '0;
									state_q      <= ST_FINISH;
								end
							end else begin
								dir_q   <= sample >= avg_q;
								mul_a_q <= mag;
								mul_b_q <= weight_q;
								state_q <= ST_STEP;
							end
						end
					end
				end

				ST_STEP: begin
					if (mul_done) begin
						avg_q <= avg_n;
						if (search_q) begin
							mul_a_q <= avg_n;
							mul_b_q <= tol_q;
							state_q <= ST_TOL;
						end else begin
							res_locked_q <= 1'b0;
							res_ticks_q  <= '0;
							res_frame_q  <= '0;
							state_q      <= ST_FINISH;
						end
					end
				end

				ST_TOL: begin
					if (mul_done) begin
						t_q       <= mul_prod;
						scaled_q  <= SW'(avg_q);
						tscaled_q <= (SW + FRAC)'(mul_prod);
						n_q       <= DW'(1);
						state_q   <= ST_SEARCH;
					end
				end

				ST_SEARCH: begin
					// try one divisor per cycle, smallest first
					if (match) begin
						res_locked_q <= 1'b1;
						res_ticks_q  <= rdld_pkg::TICK_BITS'(n_q);
						res_frame_q  <= frame_sum[FRAC+rdld_pkg::FRAME_BITS-1:FRAC];
						state_q      <= ST_FINISH;
					end else if (n_q == DW'(MAX_DIVISOR)) begin
						res_locked_q <= 1'b0;
						res_ticks_q  <= '0;
						res_frame_q  <= '0;
						state_q      <= ST_FINISH;
					end else begin
						n_q       <= n_q + DW'(1);
						scaled_q  <= scaled_q + SW'(avg_q);
						tscaled_q <= tscaled_q + (SW + FRAC)'(t_q);
					end
				end

				ST_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						locked_q <= res_locked_q;
						ticks_q  <= res_ticks_q;
						frame_q  <= res_frame_q;
						state_q  <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign locked       = locked_q;
	assign frame_ticks  = ticks_q;
	assign frame_period = frame_q;

endmodule
